// File: design/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// shared types and character codes for the source comment stripper
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int MaxRes = 3;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic REG_SCRIPT_MODE = 1'b0;

  typedef enum logic [3:0] {
    SCAN_NORMAL     = 4'd0,
    SCAN_SLASH      = 4'd1,
    SCAN_LINE       = 4'd2,
    SCAN_BLOCK      = 4'd3,
    SCAN_BLOCK_STAR = 4'd4,
    SCAN_STR        = 4'd5,
    SCAN_STR_ESC    = 4'd6,
    SCAN_QPEND      = 4'd7,
    SCAN_TRIPLE     = 4'd8,
    SCAN_TRIPLE_ESC = 4'd9
  } scan_mode_t;

  typedef struct packed {
    scan_mode_t  scan_mode;
    logic        quote_kind;
    logic [1:0]  quote_run;
  } scan_state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } scs_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_item;
    logic       end_of_text;
  } scs_out_t;

  typedef scs_out_t [MaxRes-1:0] scs_res_vec_t;

  typedef struct packed {
    scs_res_vec_t res;
    logic [1:0]   cnt;
  } scs_batch_t;

endpackage

// File: design/scs_scan.sv
// ----------------------------------------------------------------------------
// scs_scan
// one step of the comment scanner: next state and up to three results
// ----------------------------------------------------------------------------
module scs_scan import scs_pkg::*; (
  input  scs_in_t     item,
  input  logic        script_mode,
  input  scan_state_t state,
  output scan_state_t state_next,
  output scs_batch_t  batch
);

  typedef struct packed {
    scan_mode_t  scan_mode;
    logic        take_quote;
    logic        quote_kind;
    logic        emit;
    logic [7:0]  ch;
  } norm_t;

  // what a byte starts when seen in normal text
  function automatic norm_t scan_norm(input logic [7:0] b, input logic script);
    norm_t r;
    r.scan_mode  = SCAN_NORMAL;
    r.take_quote = 1'b0;
    r.quote_kind = (b == CH_SQUOTE);
    r.emit       = 1'b1;
    r.ch         = b;
    if (!script && b == CH_SLASH) begin
      r.scan_mode = SCAN_SLASH;
      r.emit      = 1'b0;
    end else if (script && b == CH_HASH) begin
      r.scan_mode = SCAN_LINE;
      r.ch        = CH_SPACE;
    end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
      r.take_quote = 1'b1;
      if (script) begin
        r.scan_mode = SCAN_QPEND;
        r.emit      = 1'b0;
      end else begin
        r.scan_mode = SCAN_STR;
      end
    end
    return r;
  endfunction

  logic [7:0] ebuf [MaxRes];
  logic [1:0] n;
  logic [7:0] b;
  logic [7:0] q;
  logic [7:0] qf;
  norm_t      nr;
  scan_mode_t md;
  logic       qk;
  logic [1:0] qr;

  always_comb begin
    for (int k = 0; k < MaxRes; k++) begin
      ebuf[k] = 8'h00;
    end
    n  = 2'd0;
    b  = item.in_byte;
    md = state.scan_mode;
    qk = state.quote_kind;
    qr = state.quote_run;
    q  = state.quote_kind ? CH_SQUOTE : CH_DQUOTE;
    nr = scan_norm(b, script_mode);

    unique case (state.scan_mode)
      SCAN_SLASH: begin
        if (b == CH_SLASH) begin
          ebuf[n] = CH_SPACE; n = n + 2'd1;
          md = SCAN_LINE;
        end else if (b == CH_STAR) begin
          ebuf[n] = CH_SPACE; n = n + 2'd1;
          md = SCAN_BLOCK;
        end else begin
          ebuf[n] = CH_SLASH; n = n + 2'd1;
          md = nr.scan_mode;
          if (nr.take_quote) begin
            qk = nr.quote_kind;
            if (script_mode) qr = 2'd1;
          end
          if (nr.emit) begin
            ebuf[n] = nr.ch; n = n + 2'd1;
          end
        end
      end
      SCAN_LINE: begin
        if (b == CH_NL) begin
          ebuf[n] = b; n = n + 2'd1;
          md = SCAN_NORMAL;
        end
      end
      SCAN_BLOCK: begin
        if (b == CH_STAR) md = SCAN_BLOCK_STAR;
      end
      SCAN_BLOCK_STAR: begin
        if (b == CH_SLASH) md = SCAN_NORMAL;
        else if (b != CH_STAR) md = SCAN_BLOCK;
      end
      SCAN_STR: begin
        ebuf[n] = b; n = n + 2'd1;
        if (b == CH_BSLASH) md = SCAN_STR_ESC;
        else if (b == q) md = SCAN_NORMAL;
        else md = SCAN_STR;
      end
      SCAN_STR_ESC: begin
        ebuf[n] = b; n = n + 2'd1;
        md = SCAN_STR;
      end
      SCAN_QPEND: begin
        if (b == q) begin
          if (state.quote_run == 2'd1) begin
            qr = 2'd2;
          end else begin
            // third quote opens a triple-quoted string
            ebuf[0] = b; ebuf[1] = b; ebuf[2] = b; n = 2'd3;
            md = SCAN_TRIPLE;
            qr = 2'd0;
          end
        end else if (state.quote_run == 2'd1) begin
          // one pending quote opened an ordinary string
          ebuf[n] = q; n = n + 2'd1;
          qr = 2'd0;
          ebuf[n] = b; n = n + 2'd1;
          if (b == CH_BSLASH) md = SCAN_STR_ESC;
          else if (b == q) md = SCAN_NORMAL;
          else md = SCAN_STR;
        end else begin
          // empty string, byte goes back to normal text
          ebuf[n] = q; n = n + 2'd1;
          ebuf[n] = q; n = n + 2'd1;
          qr = 2'd0;
          md = nr.scan_mode;
          if (nr.take_quote) begin
            qk = nr.quote_kind;
            if (script_mode) qr = 2'd1;
          end
          if (nr.emit) begin
            ebuf[n] = nr.ch; n = n + 2'd1;
          end
        end
      end
      SCAN_TRIPLE: begin
        ebuf[n] = b; n = n + 2'd1;
        if (b == CH_BSLASH) begin
          md = SCAN_TRIPLE_ESC;
          qr = 2'd0;
        end else if (b == q) begin
          qr = state.quote_run + 2'd1;
          if (qr == 2'd3) begin
            md = SCAN_NORMAL;
            qr = 2'd0;
          end
        end else begin
          qr = 2'd0;
        end
      end
      SCAN_TRIPLE_ESC: begin
        ebuf[n] = b; n = n + 2'd1;
        md = SCAN_TRIPLE;
      end
      default: begin
        md = nr.scan_mode;
        if (nr.take_quote) begin
          qk = nr.quote_kind;
          if (script_mode) qr = 2'd1;
        end
        if (nr.emit) begin
          ebuf[n] = nr.ch; n = n + 2'd1;
        end
      end
    endcase

    // end of text: flush pending bytes and return to reset state
    qf = qk ? CH_SQUOTE : CH_DQUOTE;
    if (item.is_last) begin
      if (md == SCAN_SLASH) begin
        ebuf[n] = CH_SLASH; n = n + 2'd1;
      end else if (md == SCAN_QPEND) begin
        ebuf[n] = qf; n = n + 2'd1;
        if (qr != 2'd1) begin
          ebuf[n] = qf; n = n + 2'd1;
        end
      end
      md = SCAN_NORMAL;
      qk = 1'b0;
      qr = 2'd0;
    end

    state_next.scan_mode  = md;
    state_next.quote_kind = qk;
    state_next.quote_run  = qr;

    for (int k = 0; k < MaxRes; k++) begin
      batch.res[k].out_byte     = ebuf[k];
      batch.res[k].byte_valid   = 1'b1;
      batch.res[k].last_of_item = (2'(k) == n - 2'd1);
      batch.res[k].end_of_text  = item.is_last && (2'(k) == n - 2'd1);
    end
    batch.cnt = n;
    if (item.is_last && n == 2'd0) begin
      batch.res[0].out_byte     = 8'h00;
      batch.res[0].byte_valid   = 1'b0;
      batch.res[0].last_of_item = 1'b1;
      batch.res[0].end_of_text  = 1'b1;
      batch.cnt                 = 2'd1;
    end
  end

endmodule

// File: design/scs_res_buf.sv
// ----------------------------------------------------------------------------
// scs_res_buf
// result register: holds one step's results and, while result_stall is low, sends them one per cycle
// ----------------------------------------------------------------------------
module scs_res_buf import scs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  scs_batch_t batch,
  output logic       can_load,
  output logic       result_valid,
  input  logic       result_stall,
  output scs_out_t   result
);

  scs_res_vec_t res;
  logic [1:0]   cnt;
  logic [1:0]   idx;
  logic         full;
  logic         pop;
  logic         done;

  assign pop          = full && !result_stall;
  assign done         = pop && (idx == cnt - 2'd1);
  assign can_load     = !full || done;
  assign result_valid = full;
  assign result       = res[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= 2'd0;
      cnt  <= 2'd0;
    end else if (load) begin
      full <= 1'b1;
      idx  <= 2'd0;
      cnt  <= batch.cnt;
    end else if (done) begin
      full <= 1'b0;
      idx  <= 2'd0;
    end else if (pop) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= batch.res;
    end
  end

endmodule

// File: design/source_comment_stripper_core.sv
// ----------------------------------------------------------------------------
// source_comment_stripper_core
// streaming comment stripper for c-style and script-style source text
// ----------------------------------------------------------------------------
// usage:
//   text enters one byte per request on the item channel (in_byte, is_last)
//   and leaves on the result channel, one character per request. each input
//   byte makes zero to three results; the last byte of a text always makes
//   at least one, tagged end_of_text (a bare marker if no character remains).
//   the user must set script_mode through the apb port only while the block
//   is idle; the block itself does not enforce this.
// path: a byte is captured in the input register, then scanned and loaded
//   into the result register once that register can take its results; its
//   first result shows on the result channel from the result register.
// throughput: one byte per cycle while each byte makes at most one result
//   and result_stall stays low; a byte with several results holds the
//   result register until all are sent, which can stall the item channel.
//   bytes with no result never wait on the result register.
// reset: rst (synchronous) empties both registers, returns the scanner to
//   normal text and clears script_mode.
// stall: a stalled result holds its payload; the input register keeps
//   taking bytes until it is full, then item_stall rises.
// ----------------------------------------------------------------------------
module source_comment_stripper_core import scs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // text in
  input  logic        item_valid,
  output logic        item_stall,
  input  scs_in_t     item,
  // stripped text out
  output logic        result_valid,
  input  logic        result_stall,
  output scs_out_t    result
);

  // configuration register
  logic script_mode;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      script_mode <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_SCRIPT_MODE) begin
      script_mode <= pwdata[0];
    end
  end

  // read back the one register, zero elsewhere
  always_comb begin
    prdata = 32'h0;
    if (paddr[2] == REG_SCRIPT_MODE) prdata = {31'h0, script_mode};
  end

  // input register
  scs_in_t     in_item;
  logic        in_full;
  logic        consume;
  logic        load;
  logic        can_load;
  scan_state_t state;
  scan_state_t state_next;
  scs_batch_t  batch;

  // a byte leaves the input register once its results fit, or at once
  // when it makes none
  assign consume    = in_full && (batch.cnt == 2'd0 || can_load);
  assign load       = in_full && batch.cnt != 2'd0 && can_load;
  assign item_stall = in_full && !consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_valid && !item_stall) begin
      in_full <= 1'b1;
    end else if (consume) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_item <= item;
    end
  end

  // scanner state advances once per consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state.scan_mode  <= SCAN_NORMAL;
      state.quote_kind <= 1'b0;
      state.quote_run  <= 2'd0;
    end else if (consume) begin
      state <= state_next;
    end
  end

  scs_scan u_scan (
    .item        (in_item),
    .script_mode (script_mode),
    .state       (state),
    .state_next  (state_next),
    .batch       (batch)
  );

  scs_res_buf u_res_buf (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .batch        (batch),
    .can_load     (can_load),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
